>>> hw/rtl/ptc_pkg.sv
// Shared types and constants for the pressure/temperature compensation block.
package ptc_pkg;

  // One measurement: raw temperature in the low bits.
  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_item_t;

  // One compensated result.
  typedef struct packed {
    logic        divisor_zero;
    logic [31:0] pressure_q24_8;
    logic [31:0] temperature_centi;
  } res_t;

  // Packed factory trim words, one 48-bit register each.
  typedef struct packed {
    logic [47:0] pressure_trim_high;
    logic [47:0] pressure_trim_mid;
    logic [47:0] pressure_trim_low;
    logic [47:0] temperature_trim;
  } trim_t;

  typedef enum logic [1:0] {
    REG_TEMP_TRIM  = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_MID  = 2'd2,
    REG_PRESS_HIGH = 2'd3
  } reg_idx_t;

  localparam logic [63:0] PRESS_OFFSET = 64'd128000;
  localparam logic [20:0] PRESS_FULL   = 21'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [63:0] DEN_BIAS     = 64'h0000_8000_0000_0000;

  localparam int DIV_BITS = 64;
  // Sign stage, one stage per quotient bit, sign fix stage.
  localparam int DIV_LAT  = DIV_BITS + 2;

endpackage

>>> hw/rtl/ptc_queue.sv
// Input queue: takes measurements from the stream and holds them for the datapath.
module ptc_queue
  import ptc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     pop,
  output logic     out_valid,
  output in_item_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  in_item_t        mem [0:DEPTH-1];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;

  assign in_ready  = (count != CW'(DEPTH));
  assign push      = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");
`endif

endmodule

>>> hw/rtl/ptc_mul.sv
// 64x64 multiplier giving the low 64 bits of the product, two register stages.
module ptc_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] lo_lo;
  logic [31:0] lo_hi;
  logic [31:0] hi_lo;

  // Cross terms only matter in their low 32 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      lo_lo <= 64'(a[31:0]) * 64'(b[31:0]);
      lo_hi <= a[31:0] * b[63:32];
      hi_lo <= a[63:32] * b[31:0];
      p     <= lo_lo + {lo_hi + hi_lo, 32'd0};
    end
  end

endmodule

>>> hw/rtl/ptc_div.sv
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit per stage.
module ptc_div
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo
);

  logic [63:0] rem_r [0:DIV_BITS];
  logic [63:0] quo_r [0:DIV_BITS];
  logic [63:0] den_r [0:DIV_BITS];
  logic        neg_r [0:DIV_BITS];

  // Take magnitudes; remember the sign of the quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      quo_r[0] <= num[63] ? (~num + 1'b1) : num;
      den_r[0] <= den[63] ? (~den + 1'b1) : den;
      neg_r[0] <= num[63] ^ den[63];
    end
  end

  for (genvar i = 1; i <= DIV_BITS; i++) begin : g_step
    logic [64:0] shifted;
    logic        fits;

    assign shifted = {rem_r[i-1], quo_r[i-1][63]};
    assign fits    = (shifted >= {1'b0, den_r[i-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= fits ? 64'(shifted - {1'b0, den_r[i-1]}) : shifted[63:0];
        quo_r[i] <= {quo_r[i-1][62:0], fits};
        den_r[i] <= den_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg_r[DIV_BITS] ? (~quo_r[DIV_BITS] + 1'b1) : quo_r[DIV_BITS];
    end
  end

endmodule

>>> hw/rtl/ptc_core.sv
// Compensation datapath: temperature, pressure terms, division and final correction.
module ptc_core
  import ptc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_pop,
  input  trim_t    trim,
  output logic     out_valid,
  output res_t     out_data
);

  localparam int ST_TC  = 5;
  localparam int ST_DIV = 14;
  localparam int ST_Q   = ST_DIV + DIV_LAT;
  localparam int ST_END = ST_Q + 6;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = trim.temperature_trim[15:0];
  assign t2 = trim.temperature_trim[31:16];
  assign t3 = trim.temperature_trim[47:32];
  assign p1 = trim.pressure_trim_low[15:0];
  assign p2 = trim.pressure_trim_low[31:16];
  assign p3 = trim.pressure_trim_low[47:32];
  assign p4 = trim.pressure_trim_mid[15:0];
  assign p5 = trim.pressure_trim_mid[31:16];
  assign p6 = trim.pressure_trim_mid[47:32];
  assign p7 = trim.pressure_trim_high[15:0];
  assign p8 = trim.pressure_trim_high[31:16];
  assign p9 = trim.pressure_trim_high[47:32];

  logic               vld [0:ST_END];
  in_item_t           e0;
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic [20:0]        pd_ln [1:10];
  logic signed [33:0] m1;
  logic signed [34:0] sq;
  logic signed [22:0] ta;
  logic signed [37:0] m2;
  logic signed [31:0] fine;
  logic [31:0]        tc_ln [ST_TC:ST_END];
  logic [63:0]        pa;
  logic signed [32:0] pa_s;
  logic signed [48:0] ap5_ln [6:9];
  logic signed [48:0] ap2_ln [6:9];
  logic [63:0]        aa, b1, c1;
  logic [63:0]        bsum, asum;
  logic [63:0]        sden, n0;
  logic [63:0]        dprod, nprod;
  logic [63:0]        dvs_w;
  logic [63:0]        dvs, num;
  logic               dz_ln [ST_DIV:ST_END];
  logic [63:0]        q;
  logic [63:0]        s13;
  logic [63:0]        ss, p8q, p9ss;
  logic [63:0]        q_ln [ST_Q+1:ST_Q+4];
  logic [63:0]        p8q_ln [ST_Q+3:ST_Q+4];
  logic [63:0]        psum;
  logic [31:0]        pres;

  assign in_pop = adv && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ST_END; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i <= ST_END; i++) vld[i] <= vld[i-1];
    end
  end

  // Temperature path and pressure set-up.
  always_ff @(posedge clk) begin
    if (adv) begin
      e0       <= in_data;
      d1       <= $signed({1'b0, e0.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
      d2       <= $signed({1'b0, e0.raw_temperature[19:4]}) - $signed({1'b0, t1});
      pd_ln[1] <= PRESS_FULL - {1'b0, e0.raw_pressure};
      for (int i = 2; i <= 10; i++) pd_ln[i] <= pd_ln[i-1];
      m1       <= 34'(d1) * 34'(t2);
      sq       <= 35'(d2) * 35'(d2);
      ta       <= 23'(m1 >>> 11);
      m2       <= 38'(23'(sq >>> 12)) * 38'(t3);
      fine     <= 32'(40'(ta) + 40'(m2 >>> 14));
      tc_ln[ST_TC] <= 32'((40'(fine) * 40'sd5 + 40'sd128) >>> 8);
      for (int i = ST_TC + 1; i <= ST_END; i++) tc_ln[i] <= tc_ln[i-1];
      pa       <= 64'(fine) - PRESS_OFFSET;
    end
  end

  assign pa_s = $signed(pa[32:0]);

  ptc_mul u_mul_aa (.clk(clk), .en(adv), .a(pa), .b(pa), .p(aa));
  ptc_mul u_mul_b1 (.clk(clk), .en(adv), .a(aa), .b(64'(p6)), .p(b1));
  ptc_mul u_mul_c1 (.clk(clk), .en(adv), .a(aa), .b(64'(p3)), .p(c1));

  // Divisor and dividend terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      ap5_ln[6] <= 49'(pa_s) * 49'(p5);
      ap2_ln[6] <= 49'(pa_s) * 49'(p2);
      for (int i = 7; i <= 9; i++) begin
        ap5_ln[i] <= ap5_ln[i-1];
        ap2_ln[i] <= ap2_ln[i-1];
      end
      bsum <= b1 + (64'(ap5_ln[9]) << 17) + (64'(p4) << 35);
      asum <= 64'($signed(c1) >>> 8) + (64'(ap2_ln[9]) << 12);
      sden <= DEN_BIAS + asum;
      n0   <= 64'({pd_ln[10], 31'd0}) - bsum;
    end
  end

  ptc_mul u_mul_d (.clk(clk), .en(adv), .a(sden), .b(64'(p1)), .p(dprod));
  ptc_mul u_mul_n (.clk(clk), .en(adv), .a(n0), .b(PRESS_SCALE), .p(nprod));

  assign dvs_w = 64'($signed(dprod) >>> 33);

  always_ff @(posedge clk) begin
    if (adv) begin
      dvs          <= dvs_w;
      num          <= nprod;
      dz_ln[ST_DIV] <= (dvs_w == '0);
      for (int i = ST_DIV + 1; i <= ST_END; i++) dz_ln[i] <= dz_ln[i-1];
    end
  end

  ptc_div u_div (.clk(clk), .en(adv), .num(num), .den(dvs), .quo(q));

  // Second-order correction after the division.
  assign s13 = 64'($signed(q) >>> 13);

  ptc_mul u_mul_ss  (.clk(clk), .en(adv), .a(s13), .b(s13), .p(ss));
  ptc_mul u_mul_p8  (.clk(clk), .en(adv), .a(q), .b(64'(p8)), .p(p8q));
  ptc_mul u_mul_p9  (.clk(clk), .en(adv), .a(ss), .b(64'(p9)), .p(p9ss));

  always_ff @(posedge clk) begin
    if (adv) begin
      q_ln[ST_Q+1] <= q;
      for (int i = ST_Q + 2; i <= ST_Q + 4; i++) q_ln[i] <= q_ln[i-1];
      p8q_ln[ST_Q+3] <= p8q;
      p8q_ln[ST_Q+4] <= p8q_ln[ST_Q+3];
      psum <= q_ln[ST_Q+4] + 64'($signed(p9ss) >>> 25)
            + 64'($signed(p8q_ln[ST_Q+4]) >>> 19);
      pres <= 32'(64'($signed(psum) >>> 8) + (64'(p7) << 4));
    end
  end

  assign out_valid                  = vld[ST_END];
  assign out_data.temperature_centi = tc_ln[ST_END];
  assign out_data.divisor_zero      = dz_ln[ST_END];
  assign out_data.pressure_q24_8    = dz_ln[ST_END] ? '0 : pres;

endmodule

>>> hw/rtl/pressure_temperature_compensation.sv
// Top level: trim registers, input queue, compensation datapath and output register.
//
//  channel   | direction | payload
//  s_*       | in        | tdata[19:0] raw_temperature, [39:20] raw_pressure
//  m_*       | out       | tdata[31:0] temperature_centi, [63:32] pressure_q24_8;
//            |           | tuser divisor_zero
//  APB       | in/out    | 4 trim registers at 0x00, 0x08, 0x10, 0x18
//
// One measurement per clock while the datapath is not held by m_tready.
// Results pass through the divider pipeline and the multiplier stages.
// Reset clears the queue, the pipeline valids, the output valid and all trims.
// While a result waits on m_tready the datapath holds; the queue keeps taking
// measurements until it holds QUEUE_DEPTH of them.
module pressure_temperature_compensation
  import ptc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // raw_temperature, raw_pressure
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // temperature_centi, pressure_q24_8
  output logic        m_tuser,   // divisor_zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  trim_t    trim;
  reg_idx_t reg_idx;
  logic     q_valid;
  in_item_t q_data;
  logic     q_pop;
  logic     adv;
  logic     core_valid;
  res_t     core_res;
  res_t     o_res;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      trim <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_TEMP_TRIM:  trim.temperature_trim   <= pwdata[47:0];
        REG_PRESS_LOW:  trim.pressure_trim_low  <= pwdata[47:0];
        REG_PRESS_MID:  trim.pressure_trim_mid  <= pwdata[47:0];
        REG_PRESS_HIGH: trim.pressure_trim_high <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEMP_TRIM:  prdata = {16'd0, trim.temperature_trim};
      REG_PRESS_LOW:  prdata = {16'd0, trim.pressure_trim_low};
      REG_PRESS_MID:  prdata = {16'd0, trim.pressure_trim_mid};
      REG_PRESS_HIGH: prdata = {16'd0, trim.pressure_trim_high};
      default:        prdata = '0;
    endcase
  end

  ptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_item_t'(s_tdata)),
    .pop       (q_pop),
    .out_valid (q_valid),
    .out_data  (q_data)
  );

  // Advance the datapath whenever the output register is free or being drained.
  assign adv = !m_tvalid || m_tready;

  ptc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (q_valid),
    .in_data   (q_data),
    .in_pop    (q_pop),
    .trim      (trim),
    .out_valid (core_valid),
    .out_data  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_res <= core_res;
    end
  end

  assign m_tdata = {o_res.pressure_q24_8, o_res.temperature_centi};
  assign m_tuser = o_res.divisor_zero;

endmodule
